>>> rtl/clipped_line_rasterizer_unit_assert.svh
// Assertion macros for the clipped line rasterizer.
// Used by the top level only; needs a clk and rst in scope.
`ifndef CLIPPED_LINE_RASTERIZER_UNIT_ASSERT_SVH
`define CLIPPED_LINE_RASTERIZER_UNIT_ASSERT_SVH

// same-cycle implication
`define CLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/clr_pkg.sv
// Shared types and constants of the clipped line rasterizer.
// No dependencies; the channels and every module import it.
package clr_pkg;

  localparam int COORD_BITS     = 8;
  localparam int MAX_SCREEN_DIM = 64;
  localparam int CFG_BITS       = 7;
  localparam int COLOR_BITS     = 16;
  localparam int SCREEN_RESET   = 64;

  localparam int DIM_BITS   = $clog2(MAX_SCREEN_DIM + 1);
  localparam int PIX_BITS   = $clog2(MAX_SCREEN_DIM);
  localparam int ADDR_BITS  = 2 * PIX_BITS;
  localparam int DELTA_BITS = COORD_BITS + 2;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int E2_BITS    = ERR_BITS + 1;
  localparam int CMP_BITS   = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS) + 1;
  localparam int IDX_BITS   = 1;

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic [DIM_BITS-1:0]          dim_t;
  typedef logic [PIX_BITS-1:0]          pix_t;
  typedef logic [ADDR_BITS-1:0]         addr_t;
  typedef logic [COLOR_BITS-1:0]        color_t;

  // walk position and error
  typedef struct packed {
    coord_t x;
    coord_t y;
    err_t   err;
  } pos_t;

  // per-line constants of the walk
  typedef struct packed {
    coord_t tx;
    coord_t ty;
    delta_t dx;
    delta_t dy;
    logic   sx;
    logic   sy;
  } line_t;

  // one pixel handed to the output stage
  typedef struct packed {
    pix_t   x;
    pix_t   y;
    dim_t   width;
    color_t color;
    logic   last;
  } emit_req_t;

  typedef struct packed {
    logic idle;
    logic pend_valid;
  } walk_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_t;

endpackage

>>> rtl/clr_channels.sv
// Handshake channels of the rasterizer: line commands in, pixel words out.
// Depends on clr_pkg.
interface clr_cmd_if;
  import clr_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;
  color_t line_color;

  modport source (output valid, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, line_color,
                output ready);
endinterface

interface clr_pix_if;
  import clr_pkg::*;
  logic   valid;
  logic   ready;
  pix_t   pixel_x;
  pix_t   pixel_y;
  addr_t  pixel_addr;
  color_t pixel_color;
  logic   last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_addr, pixel_color, last_pixel,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pixel_addr, pixel_color, last_pixel,
                output ready);
endinterface

>>> rtl/clr_step_unit.sv
// One Bresenham step: error doubling, both compares, error and position update.
// Depends on clr_pkg.
module clr_step_unit (
  input  clr_pkg::pos_t  cur,
  input  clr_pkg::line_t line,
  output clr_pkg::pos_t  nxt,
  output logic           at_end
);
  import clr_pkg::*;

  logic signed [E2_BITS-1:0] e2;
  logic signed [E2_BITS-1:0] dx_e;
  logic signed [E2_BITS-1:0] dy_e;
  logic                      x_step;
  logic                      y_step;
  err_t                      inc_x;
  err_t                      inc_y;

  always_comb begin
    e2     = $signed({cur.err, 1'b0});
    dx_e   = E2_BITS'($signed(line.dx));
    dy_e   = E2_BITS'($signed(line.dy));
    x_step = (e2 >= dy_e);
    y_step = (e2 <= dx_e);
    inc_x  = x_step ? ERR_BITS'($signed(line.dy)) : '0;
    inc_y  = y_step ? ERR_BITS'($signed(line.dx)) : '0;

    nxt.err = cur.err + inc_x + inc_y;
    nxt.x   = cur.x;
    nxt.y   = cur.y;
    if (x_step) begin
      nxt.x = line.sx ? cur.x + coord_t'(1) : cur.x - coord_t'(1);
    end
    if (y_step) begin
      nxt.y = line.sy ? cur.y + coord_t'(1) : cur.y - coord_t'(1);
    end
    at_end = (cur.x == line.tx) && (cur.y == line.ty);
  end

endmodule

>>> rtl/clr_emit.sv
// Output register of the pixel channel; forms the framebuffer address.
// Depends on clr_pkg and clr_channels.
module clr_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  clr_pkg::emit_req_t req,
  output logic               emit_ready,
  clr_pix_if.source          pix
);
  import clr_pkg::*;

  localparam int PROD_BITS = PIX_BITS + DIM_BITS;

  logic [PROD_BITS-1:0] addr_full;

  // row * stride + column
  assign addr_full = PROD_BITS'(req.y) * PROD_BITS'(req.width) + PROD_BITS'(req.x);

  assign emit_ready = !pix.valid || pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else if (push) begin
      pix.valid <= 1'b1;
    end else if (pix.ready) begin
      pix.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pix.pixel_x     <= req.x;
      pix.pixel_y     <= req.y;
      pix.pixel_addr  <= addr_full[ADDR_BITS-1:0];
      pix.pixel_color <= req.color;
      pix.last_pixel  <= req.last;
    end
  end

endmodule

>>> rtl/clr_walker.sv
// Line sequencer: command setup, the stepping loop, clipping and the
// one-pixel lookahead that marks the last visible pixel. Depends on clr_pkg,
// clr_channels, clr_step_unit.
module clr_walker (
  input  logic                clk,
  input  logic                rst,
  input  clr_pkg::dim_t       eff_w,
  input  clr_pkg::dim_t       eff_h,
  clr_cmd_if.sink             cmd,
  input  logic                emit_ready,
  output logic                push,
  output clr_pkg::emit_req_t  req,
  output clr_pkg::walk_stat_t stat
);
  import clr_pkg::*;

  state_t state, state_next;
  pos_t   pos, pos_next;
  line_t  line, line_next;
  dim_t   w_line, h_line;
  color_t color;
  pix_t   pend_x, pend_y;
  logic   pend_valid, pend_valid_next;
  logic   pend_load;
  logic   cmd_take;

  pos_t   stepped;
  logic   at_end;
  logic   visible;

  // setup of a new command
  coord_t s_x, e_x;
  delta_t dx_in, dy_in;

  clr_step_unit u_step (
    .cur    (pos),
    .line   (line),
    .nxt    (stepped),
    .at_end (at_end)
  );

  always_comb begin
    visible = !pos.x[COORD_BITS-1] && !pos.y[COORD_BITS-1]
           && (CMP_BITS'($unsigned(pos.x)) < CMP_BITS'(w_line))
           && (CMP_BITS'($unsigned(pos.y)) < CMP_BITS'(h_line));
  end

  // horizontal span runs from the lower column up
  always_comb begin
    s_x = cmd.start_x;
    e_x = cmd.end_x;
    if ((cmd.start_y == cmd.end_y) && (cmd.start_x > cmd.end_x)) begin
      s_x = cmd.end_x;
      e_x = cmd.start_x;
    end
    dx_in = (e_x > s_x) ? delta_t'(e_x) - delta_t'(s_x) : delta_t'(s_x) - delta_t'(e_x);
    dy_in = (cmd.end_y > cmd.start_y) ? delta_t'(cmd.start_y) - delta_t'(cmd.end_y)
                                      : delta_t'(cmd.end_y) - delta_t'(cmd.start_y);
  end

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_take  = cmd.valid && cmd.ready;

  always_comb begin
    state_next      = state;
    pos_next        = pos;
    line_next       = line;
    pend_valid_next = pend_valid;
    pend_load       = 1'b0;
    push            = 1'b0;
    req.x           = pend_x;
    req.y           = pend_y;
    req.width       = w_line;
    req.color       = color;
    req.last        = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          pos_next.x      = s_x;
          pos_next.y      = cmd.start_y;
          pos_next.err    = ERR_BITS'(dx_in) + ERR_BITS'(dy_in);
          line_next.tx    = e_x;
          line_next.ty    = cmd.end_y;
          line_next.dx    = dx_in;
          line_next.dy    = dy_in;
          line_next.sx    = (s_x < e_x);
          line_next.sy    = (cmd.start_y < cmd.end_y);
          pend_valid_next = 1'b0;
          state_next      = ST_WALK;
        end
      end
      ST_WALK: begin
        // a second visible pixel must wait while the held one cannot leave
        if (!(visible && pend_valid && !emit_ready)) begin
          if (visible) begin
            push            = pend_valid;
            pend_load       = 1'b1;
            pend_valid_next = 1'b1;
          end
          if (at_end) begin
            state_next = ST_FLUSH;
          end else begin
            pos_next = stepped;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (emit_ready) begin
          push            = 1'b1;
          req.last        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    line <= line_next;
    if (cmd_take) begin
      w_line <= eff_w;
      h_line <= eff_h;
      color  <= cmd.line_color;
    end
    if (pend_load) begin
      pend_x <= PIX_BITS'($unsigned(pos.x));
      pend_y <= PIX_BITS'($unsigned(pos.y));
    end
  end

  assign stat.idle       = (state == ST_IDLE);
  assign stat.pend_valid = pend_valid;

endmodule

>>> rtl/clipped_line_rasterizer_unit.sv
// Clipped Bresenham line rasterizer, one line command in, one word per visible pixel out.
// The first word is pushed into the output register when the walk reaches the second visible
// pixel, or from the flush state after the line end when no second one comes; a command holds
// the block until its flush is done, paced by the single step unit that advances one pixel a
// cycle while the output does not stall. Synchronous active-high reset: idle, no word pending,
// screen 64 x 64.
module clipped_line_rasterizer_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [clr_pkg::IDX_BITS-1:0] cfg_idx,
  input  logic [clr_pkg::CFG_BITS-1:0] cfg_data,
  clr_cmd_if.sink                  cmd,
  clr_pix_if.source                pix
);
  import clr_pkg::*;

  // screen registers as written
  logic [CFG_BITS-1:0] screen_width;
  logic [CFG_BITS-1:0] screen_height;

  // clamped to the largest supported screen
  dim_t eff_w;
  dim_t eff_h;

  logic       push;
  logic       emit_ready;
  emit_req_t  req;
  walk_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= CFG_BITS'(SCREEN_RESET);
      screen_height <= CFG_BITS'(SCREEN_RESET);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    eff_w = (int'(screen_width) > MAX_SCREEN_DIM) ? DIM_BITS'(MAX_SCREEN_DIM)
                                                  : DIM_BITS'(screen_width);
    eff_h = (int'(screen_height) > MAX_SCREEN_DIM) ? DIM_BITS'(MAX_SCREEN_DIM)
                                                   : DIM_BITS'(screen_height);
  end

  // sequencer: setup, one Bresenham step per cycle unless the output stalls, clip, lookahead of one pixel
  clr_walker u_walker (
    .clk        (clk),
    .rst        (rst),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .cmd        (cmd),
    .emit_ready (emit_ready),
    .push       (push),
    .req        (req),
    .stat       (stat)
  );

  // output word register and address multiply
  clr_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .req        (req),
    .emit_ready (emit_ready),
    .pix        (pix)
  );

`include "clipped_line_rasterizer_unit_assert.svh"

  // a taken command keeps the block busy for at least the next cycle
  `CLR_ASSERT_NEXT(a_busy_after_cmd, cmd.valid && cmd.ready, !cmd.ready, "ready after command")
  // a new command starts with no held pixel
  `CLR_ASSERT_NEXT(a_pend_clear, cmd.valid && cmd.ready, !stat.pend_valid, "stale held pixel")
  // back in idle means the last pixel has been handed over
  `CLR_ASSERT_NOW(a_idle_empty, stat.idle, !stat.pend_valid, "held pixel lost at idle")

endmodule
